FILE: rtl/core/amm_pkg.sv
// Package for the accelerometer mean / magnitude block.
// Shared field widths, default capacity and queue depth. No dependencies.
`timescale 1ns / 1ps

package amm_pkg;

   localparam int ACC_W           = 16;   // one axis sample / mean
   localparam int MAG_W           = 16;   // magnitude field
   localparam int SQ_W            = 32;   // sum of three squared means
   localparam int ROOT_STEPS      = SQ_W / 2;
   localparam int MAX_SAMPLES_DEF = 512;
   localparam int JOB_DEPTH       = 2;    // batches waiting between front and back

endpackage

FILE: rtl/core/accel_mean_magnitude.sv
// Sample items are taken at one per cycle while not stalled. A batch's sums
// are handed to a two-entry queue on its last item; the back end then runs
// the one-bit-per-cycle divider once per axis over SUM_W = 16 +
// clog2(MAX_SAMPLES+1) quotient bits, then the 16-step square root. The
// result stays in its output register until taken, and the next waiting
// batch is taken in the cycle after that. A last item is stalled only while
// two finished batches still wait for the back end; other items are never
// stalled.
// Samples beyond MAX_SAMPLES are ignored and reported through rsp_dropped.
// Uses amm_pkg, amm_front, amm_queue, amm_back.
`timescale 1ns / 1ps

module accel_mean_magnitude import amm_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [ACC_W-1:0] req_acc_x,
   input  logic signed [ACC_W-1:0] req_acc_y,
   input  logic signed [ACC_W-1:0] req_acc_z,
   input  logic                    req_last_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [ACC_W-1:0] rsp_mean_x,
   output logic signed [ACC_W-1:0] rsp_mean_y,
   output logic signed [ACC_W-1:0] rsp_mean_z,
   output logic [MAG_W-1:0]        rsp_magnitude,
   output logic [CNT_W-1:0]        rsp_samples_used,
   output logic                    rsp_dropped
);

   localparam int SUM_W = ACC_W + CNT_W;
   localparam int JOB_W = 3 * SUM_W + CNT_W + 1;

   logic             push_valid, push_ready;
   logic [JOB_W-1:0] push_data;
   logic             job_valid, job_pop;
   logic [JOB_W-1:0] job_data;

   amm_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_acc_x       (req_acc_x),
      .req_acc_y       (req_acc_y),
      .req_acc_z       (req_acc_z),
      .req_last_sample (req_last_sample),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   amm_queue #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (job_valid),
      .pop_ready  (job_pop),
      .pop_data   (job_data)
   );

   amm_back #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job_pop          (job_pop),
      .job_data         (job_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_x       (rsp_mean_x),
      .rsp_mean_y       (rsp_mean_y),
      .rsp_mean_z       (rsp_mean_z),
      .rsp_magnitude    (rsp_magnitude),
      .rsp_samples_used (rsp_samples_used),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

FILE: rtl/core/amm_front.sv
// Front end: takes sample items, keeps per-axis sums and a count,
// and hands a finished batch to the job queue. Uses amm_pkg.
`timescale 1ns / 1ps

module amm_front import amm_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
   localparam int SUM_W = ACC_W + CNT_W,
   localparam int JOB_W = 3 * SUM_W + CNT_W + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [ACC_W-1:0] req_acc_x,
   input  logic signed [ACC_W-1:0] req_acc_y,
   input  logic signed [ACC_W-1:0] req_acc_z,
   input  logic                    req_last_sample,
   output logic                    push_valid,
   input  logic                    push_ready,
   output logic [JOB_W-1:0]        push_data
);

   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [SUM_W-1:0] sum_x_in, sum_y_in, sum_z_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    overflow_ff, overflow_in;
   logic                    room;
   logic                    accept;

   // only a closing item needs queue space
   assign req_stall  = req_last_sample & ~push_ready;
   assign accept     = req_valid & ~req_stall;
   assign push_valid = accept & req_last_sample;
   assign push_data  = {overflow_in, count_in, sum_z_in, sum_y_in, sum_x_in};

   always_comb begin
      room        = count_ff < CNT_W'(MAX_SAMPLES);
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      sum_z_in    = sum_z_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff | ~room;
      if (room) begin
         sum_x_in = sum_x_ff + {{(SUM_W-ACC_W){req_acc_x[ACC_W-1]}}, req_acc_x};
         sum_y_in = sum_y_ff + {{(SUM_W-ACC_W){req_acc_y[ACC_W-1]}}, req_acc_y};
         sum_z_in = sum_z_ff + {{(SUM_W-ACC_W){req_acc_z[ACC_W-1]}}, req_acc_z};
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sum_z_ff    <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         if (req_last_sample) begin
            sum_x_ff    <= '0;
            sum_y_ff    <= '0;
            sum_z_ff    <= '0;
            count_ff    <= '0;
            overflow_ff <= 1'b0;
         end else begin
            sum_x_ff    <= sum_x_in;
            sum_y_ff    <= sum_y_in;
            sum_z_ff    <= sum_z_in;
            count_ff    <= count_in;
            overflow_ff <= overflow_in;
         end
      end
   end

endmodule

FILE: rtl/core/amm_queue.sv
// Small FIFO of finished batches between front and back.
// Generic width and depth; no package dependencies.
`timescale 1ns / 1ps

module amm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FILL_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              do_push, do_pop;

   assign push_ready = fill_ff != FILL_W'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push & ~do_pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (do_pop & ~do_push) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

endmodule

FILE: rtl/core/amm_back.sv
// Back end: serial divide of each axis sum by the count, squares through one
// multiplier, bit-pair integer square root, result register. Uses amm_pkg.
`timescale 1ns / 1ps

module amm_back import amm_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
   localparam int SUM_W = ACC_W + CNT_W,
   localparam int JOB_W = 3 * SUM_W + CNT_W + 1,
   localparam int DIV_CNT_W = $clog2(SUM_W),
   localparam int ROOT_CNT_W = $clog2(ROOT_STEPS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_pop,
   input  logic [JOB_W-1:0]        job_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [ACC_W-1:0] rsp_mean_x,
   output logic signed [ACC_W-1:0] rsp_mean_y,
   output logic signed [ACC_W-1:0] rsp_mean_z,
   output logic [MAG_W-1:0]        rsp_magnitude,
   output logic [CNT_W-1:0]        rsp_samples_used,
   output logic                    rsp_dropped
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_DIV, ST_FIX, ST_SQ, ST_ROOT, ST_OUT
   } state_type;

   state_type             state_ff;
   logic [SUM_W-1:0]      sum_ff [3];
   logic [CNT_W-1:0]      cnt_ff;
   logic                  drop_ff;
   logic [1:0]            axis_ff;
   logic                  neg_ff;
   logic [SUM_W-1:0]      quo_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [ACC_W-1:0]      mean_ff [3];
   logic [1:0]            step_ff;
   logic [SQ_W-1:0]       prod_ff;
   logic [SQ_W-1:0]       sq_acc_ff;
   logic [SQ_W-1:0]       root_rem_ff;
   logic [SQ_W-1:0]       root_res_ff;
   logic [SQ_W-1:0]       root_bit_ff;
   logic [ROOT_CNT_W-1:0] root_cnt_ff;
   logic                  rsp_valid_ff;

   // divider step
   logic [CNT_W:0]        rem_sh;
   logic                  div_ge;
   logic [CNT_W-1:0]      rem_in;
   logic [SUM_W-1:0]      quo_in;
   logic [SUM_W-1:0]      sum_sel, sum_abs;
   // square step
   logic [1:0]            sq_sel;
   logic signed [2*ACC_W-1:0] sq_prod;
   logic [SQ_W-1:0]       sq_acc_in;
   // root step
   logic [SQ_W-1:0]       root_trial;
   logic                  root_ge;
   logic [SQ_W-1:0]       root_rem_in, root_res_in;

   always_comb begin
      sum_sel = sum_ff[axis_ff];
      sum_abs = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;

      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      div_ge = rem_sh >= {1'b0, cnt_ff};
      rem_in = div_ge ? CNT_W'(rem_sh - {1'b0, cnt_ff}) : rem_sh[CNT_W-1:0];
      quo_in = {quo_ff[SUM_W-2:0], div_ge};

      sq_sel    = (step_ff == 2'd3) ? 2'd0 : step_ff;
      sq_prod   = $signed(mean_ff[sq_sel]) * $signed(mean_ff[sq_sel]);
      sq_acc_in = sq_acc_ff + prod_ff;

      root_trial  = root_res_ff + root_bit_ff;
      root_ge     = root_rem_ff >= root_trial;
      root_rem_in = root_ge ? root_rem_ff - root_trial : root_rem_ff;
      root_res_in = root_ge ? (root_res_ff >> 1) + root_bit_ff : root_res_ff >> 1;
   end

   assign job_pop          = (state_ff == ST_IDLE) & job_valid;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_x       = mean_ff[0];
   assign rsp_mean_y       = mean_ff[1];
   assign rsp_mean_z       = mean_ff[2];
   assign rsp_magnitude    = root_res_ff[MAG_W-1:0];
   assign rsp_samples_used = cnt_ff;
   assign rsp_dropped      = drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  sum_ff[0] <= job_data[SUM_W-1:0];
                  sum_ff[1] <= job_data[2*SUM_W-1:SUM_W];
                  sum_ff[2] <= job_data[3*SUM_W-1:2*SUM_W];
                  cnt_ff    <= job_data[3*SUM_W+CNT_W-1:3*SUM_W];
                  drop_ff   <= job_data[JOB_W-1];
                  axis_ff   <= 2'd0;
                  state_ff  <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               neg_ff     <= sum_sel[SUM_W-1];
               quo_ff     <= sum_abs;
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               quo_ff     <= quo_in;
               rem_ff     <= rem_in;
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               // truncation toward zero: divide magnitudes, restore the sign
               mean_ff[axis_ff] <= neg_ff ? ACC_W'(~quo_ff[ACC_W-1:0] + ACC_W'(1))
                                          : quo_ff[ACC_W-1:0];
               if (axis_ff == 2'd2) begin
                  step_ff   <= 2'd0;
                  sq_acc_ff <= '0;
                  state_ff  <= ST_SQ;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_SQ: begin
               // product registered, added in the following cycle
               prod_ff <= SQ_W'(sq_prod);
               step_ff <= step_ff + 2'd1;
               if (step_ff != 2'd0) begin
                  sq_acc_ff <= sq_acc_in;
               end
               if (step_ff == 2'd3) begin
                  root_rem_ff <= sq_acc_in;
                  root_res_ff <= '0;
                  root_bit_ff <= SQ_W'(1) << (SQ_W - 2);
                  root_cnt_ff <= '0;
                  state_ff    <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               root_rem_ff <= root_rem_in;
               root_res_ff <= root_res_in;
               root_bit_ff <= root_bit_ff >> 2;
               root_cnt_ff <= root_cnt_ff + ROOT_CNT_W'(1);
               if (root_cnt_ff == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (~rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   // a batch always holds at least one sample
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_samples_used != '0))
      else $error("result with zero sample count");

   // magnitude is the floor root of the squared-mean sum
   a_root_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({18'd0, rsp_magnitude} * {18'd0, rsp_magnitude}) <=
                     {2'b00, sq_acc_ff}))
      else $error("magnitude too large");

   a_root_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((({18'd0, rsp_magnitude} + 34'd1) *
                      ({18'd0, rsp_magnitude} + 34'd1)) > {2'b00, sq_acc_ff}))
      else $error("magnitude too small");

   // a new batch is never taken while a result waits
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ~job_pop)
      else $error("job popped while result pending");

endmodule
